@@ design/spdg_pkg.sv @@
// shared types, constants and microcode program for the dense-graph shortest path block
package spdg_pkg;

	localparam int VERTICES_DEF    = 16;
	localparam int WEIGHT_BITS_DEF = 8;
	localparam int OUT_MAX         = 16;

	localparam logic [15:0] DIST_INF = 16'hFFFF;
	localparam logic [15:0] DIST_MAX = 16'hFFFE;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;

	typedef struct packed {
		logic       func;
		logic [3:0] from_vertex;
		logic [3:0] to_vertex;
		logic [7:0] edge_weight;
	} req_t;

	typedef struct packed {
		logic [3:0]  vertex;
		logic [15:0] distance;
		logic [3:0]  parent_vertex;
		logic        has_parent;
		logic        reached;
		logic        last;
	} rsp_t;

	typedef logic [3:0] step_t;

	localparam step_t S_IDLE     = 4'd0;
	localparam step_t S_SEL_RD   = 4'd1;
	localparam step_t S_SEL_CHK  = 4'd2;
	localparam step_t S_SEL_END  = 4'd3;
	localparam step_t S_REL_RD   = 4'd4;
	localparam step_t S_REL_CHK  = 4'd5;
	localparam step_t S_ROUND    = 4'd6;
	localparam step_t S_OUT_RD   = 4'd7;
	localparam step_t S_OUT_EMIT = 4'd8;
	localparam step_t S_DONE     = 4'd9;

	typedef enum logic [2:0] {
		C_NEXT   = 3'd0,
		C_ALWAYS = 3'd1,
		C_IDLE   = 3'd2,
		C_MORE   = 3'd3,
		C_NONE   = 3'd4
	} cond_t;

	typedef struct packed {
		logic  ready;
		logic  rd_dist;
		logic  rd_wt;
		logic  sel_chk;
		logic  sel_end;
		logic  rel_chk;
		logic  round_clr;
		logic  out_emit;
		logic  out_lim;
		logic  step_cnt;
		cond_t cond;
		step_t target;
	} ucw_t;

	function automatic ucw_t ucode(input step_t step);
		ucw_t uc;
		uc = '0;
		case (step)
			S_IDLE: begin
				uc.ready  = 1'b1;
				uc.cond   = C_IDLE;
				uc.target = S_IDLE;
			end
			S_SEL_RD: begin
				uc.rd_dist = 1'b1;
				uc.cond    = C_NEXT;
			end
			S_SEL_CHK: begin
				uc.sel_chk  = 1'b1;
				uc.step_cnt = 1'b1;
				uc.cond     = C_MORE;
				uc.target   = S_SEL_RD;
			end
			S_SEL_END: begin
				uc.sel_end = 1'b1;
				uc.cond    = C_NONE;
				uc.target  = S_OUT_RD;
			end
			S_REL_RD: begin
				uc.rd_dist = 1'b1;
				uc.rd_wt   = 1'b1;
				uc.cond    = C_NEXT;
			end
			S_REL_CHK: begin
				uc.rel_chk  = 1'b1;
				uc.step_cnt = 1'b1;
				uc.cond     = C_MORE;
				uc.target   = S_REL_RD;
			end
			S_ROUND: begin
				uc.round_clr = 1'b1;
				uc.cond      = C_ALWAYS;
				uc.target    = S_SEL_RD;
			end
			S_OUT_RD: begin
				uc.rd_dist = 1'b1;
				uc.out_lim = 1'b1;
				uc.cond    = C_NEXT;
			end
			S_OUT_EMIT: begin
				uc.out_emit = 1'b1;
				uc.out_lim  = 1'b1;
				uc.step_cnt = 1'b1;
				uc.cond     = C_MORE;
				uc.target   = S_OUT_RD;
			end
			S_DONE: begin
				uc.cond   = C_ALWAYS;
				uc.target = S_IDLE;
			end
			default: begin
				uc.cond   = C_ALWAYS;
				uc.target = S_IDLE;
			end
		endcase
		return uc;
	endfunction

endpackage

@@ design/spdg_chan_if.sv @@
// valid/ready channel interface carrying one payload of type T
interface spdg_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/shortest_path_dense_graph_top.sv @@
// dense-graph single-source shortest path, microcoded sequencer over matrix and vertex memories
//
//  channel | dir | payload                                              | handshake
//  req     | in  | func, from_vertex, to_vertex, edge_weight            | valid/ready
//  rsp     | out | vertex, distance, parent_vertex, has_parent,         | valid/ready
//          |     | reached, last                                        |
//
// a load request writes one matrix entry; ready is high only at the sequencer's idle step
// a run repeats rounds of a selection scan and a relaxation scan, one distance/weight memory read
// per scan step, until no vertex is selected; then it emits min(VERTICES,16) results
// rsp stalls hold the sequencer at its emit step; no clearing pass after reset
// a run request whose source is out of range is dropped and the block stays idle
module shortest_path_dense_graph_top #(
	parameter int VERTICES    = spdg_pkg::VERTICES_DEF,
	parameter int WEIGHT_BITS = spdg_pkg::WEIGHT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spdg_chan_if.sink     req,
	spdg_chan_if.source   rsp
);

	localparam int VW        = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int AW        = $clog2(VERTICES * VERTICES);
	localparam int OUT_COUNT = (VERTICES < spdg_pkg::OUT_MAX) ? VERTICES : spdg_pkg::OUT_MAX;
	localparam logic [VW-1:0] V_LAST   = VW'(VERTICES - 1);
	localparam logic [VW-1:0] OUT_LAST = VW'(OUT_COUNT - 1);
	localparam logic [VERTICES-1:0] VBIT0 = VERTICES'(1);

	spdg_pkg::ucw_t  ucw;
	spdg_pkg::step_t pc_q;
	spdg_pkg::step_t pc_nxt;
	spdg_pkg::rsp_t  rsp_q;

	logic [VW-1:0]          cnt_q;
	logic [VW-1:0]          cnt_nxt;
	logic [VW-1:0]          pick_q;
	logic [VW-1:0]          src_idx;
	logic [15:0]            least_q;
	logic                   found_q;
	logic [VERTICES-1:0]    settled_q;
	logic [VERTICES-1:0]    dvalid_q;
	logic [VERTICES-1:0]    pvalid_q;
	logic                   out_valid_q;

	logic [15:0]            dist_mem [VERTICES];
	logic [VW-1:0]          pred_mem [VERTICES];
	logic [WEIGHT_BITS-1:0] wt_mem [VERTICES*VERTICES];
	logic [15:0]            dist_rd_q;
	logic [VW-1:0]          pred_rd_q;
	logic [WEIGHT_BITS-1:0] wt_rd_q;

	logic          req_fire;
	logic          is_run;
	logic          src_ok;
	logic          col_ok;
	logic          run_go;
	logic          load_go;
	logic          cnt_last;
	logic          take;
	logic          out_busy;
	logic          stall;
	logic          emit_go;
	logic          better;
	logic          relax;
	logic [15:0]   dist_cur;
	logic [15:0]   wt_ext;
	logic [16:0]   sum_full;
	logic [15:0]   sum_sat;
	logic [AW-1:0] load_addr;
	logic [AW-1:0] rel_addr;

	assign ucw       = spdg_pkg::ucode(pc_q);
	assign req.ready = ucw.ready;
	assign req_fire  = req.valid && req.ready;
	assign is_run    = req.data.func == spdg_pkg::FUNC_RUN;
	assign src_ok    = int'(req.data.from_vertex) < VERTICES;
	assign col_ok    = int'(req.data.to_vertex) < VERTICES;
	assign run_go    = req_fire && is_run && src_ok;
	assign load_go   = req_fire && !is_run && src_ok && col_ok;
	assign src_idx   = VW'(req.data.from_vertex);
	assign load_addr = AW'(int'(req.data.from_vertex) * VERTICES + int'(req.data.to_vertex));
	assign rel_addr  = AW'(int'(pick_q) * VERTICES + int'(cnt_q));

	assign cnt_last = ucw.out_lim ? (cnt_q == OUT_LAST) : (cnt_q == V_LAST);
	assign cnt_nxt  = cnt_last ? '0 : cnt_q + VW'(1);

	assign dist_cur = dvalid_q[cnt_q] ? dist_rd_q : spdg_pkg::DIST_INF;
	assign wt_ext   = 16'(wt_rd_q);
	assign sum_full = {1'b0, least_q} + {1'b0, wt_ext};
	assign sum_sat  = (sum_full > {1'b0, spdg_pkg::DIST_MAX}) ? spdg_pkg::DIST_MAX : sum_full[15:0];

	assign better = ucw.sel_chk && !settled_q[cnt_q] && (dist_cur < least_q);
	assign relax  = ucw.rel_chk && (wt_rd_q != '0) && !settled_q[cnt_q] && (dist_cur > sum_sat);

	assign out_busy = out_valid_q && !rsp.ready;
	assign stall    = ucw.out_emit && out_busy;
	assign emit_go  = ucw.out_emit && !out_busy;

	always_comb begin
		case (ucw.cond)
			spdg_pkg::C_NEXT:   take = 1'b0;
			spdg_pkg::C_ALWAYS: take = 1'b1;
			spdg_pkg::C_IDLE:   take = !run_go;
			spdg_pkg::C_MORE:   take = !cnt_last;
			spdg_pkg::C_NONE:   take = !found_q;
			default:            take = 1'b0;
		endcase
		if (stall) begin
			pc_nxt = pc_q;
		end else if (take) begin
			pc_nxt = ucw.target;
		end else begin
			pc_nxt = pc_q + 4'd1;
		end
	end

	// sequencer and search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= spdg_pkg::S_IDLE;
			cnt_q     <= '0;
			pick_q    <= '0;
			least_q   <= spdg_pkg::DIST_INF;
			found_q   <= 1'b0;
			settled_q <= '0;
			dvalid_q  <= '0;
			pvalid_q  <= '0;
		end else begin
			pc_q <= pc_nxt;
			if (ucw.step_cnt && !stall) begin
				cnt_q <= cnt_nxt;
			end
			if (run_go) begin
				settled_q <= '0;
				dvalid_q  <= VBIT0 << src_idx;
				pvalid_q  <= '0;
				least_q   <= spdg_pkg::DIST_INF;
				found_q   <= 1'b0;
			end
			if (ucw.round_clr) begin
				least_q <= spdg_pkg::DIST_INF;
				found_q <= 1'b0;
			end
			if (better) begin
				least_q <= dist_cur;
				pick_q  <= cnt_q;
				found_q <= 1'b1;
			end
			if (ucw.sel_end && found_q) begin
				settled_q[pick_q] <= 1'b1;
			end
			if (relax) begin
				dvalid_q[cnt_q] <= 1'b1;
				pvalid_q[cnt_q] <= 1'b1;
			end
		end
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (run_go) begin
			dist_mem[src_idx] <= '0;
		end else if (relax) begin
			dist_mem[cnt_q] <= sum_sat;
		end
		if (ucw.rd_dist) begin
			dist_rd_q <= dist_mem[cnt_q];
		end
	end

	// predecessor memory
	always_ff @(posedge clk) begin
		if (relax) begin
			pred_mem[cnt_q] <= pick_q;
		end
		if (ucw.rd_dist) begin
			pred_rd_q <= pred_mem[cnt_q];
		end
	end

	// weight matrix memory
	always_ff @(posedge clk) begin
		if (load_go) begin
			wt_mem[load_addr] <= WEIGHT_BITS'(16'(req.data.edge_weight));
		end
		if (ucw.rd_wt) begin
			wt_rd_q <= wt_mem[rel_addr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_q.vertex        <= 4'(cnt_q);
			rsp_q.distance      <= (dist_cur == spdg_pkg::DIST_INF) ? 16'd0 : dist_cur;
			rsp_q.reached       <= dist_cur != spdg_pkg::DIST_INF;
			rsp_q.has_parent    <= pvalid_q[cnt_q];
			rsp_q.parent_vertex <= pvalid_q[cnt_q] ? 4'(pred_rd_q) : 4'd0;
			rsp_q.last          <= cnt_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= spdg_pkg::S_DONE)
		else $error("sequencer step out of program");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> (settled_q == '0) && (pvalid_q == '0))
		else $error("search state not cleared at run start");

	a_found_finite: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (least_q != spdg_pkg::DIST_INF))
		else $error("selected vertex has infinite distance");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && cnt_last) |=> (pc_q == spdg_pkg::S_DONE))
		else $error("sequencer kept emitting after last result");

	a_emit_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(pc_q) == spdg_pkg::S_OUT_EMIT))
		else $error("result loaded outside emit step");

endmodule
